@@ sv/wmbd_pkg.sv @@
// ----------------------------------------------------------------------------
// wmbd_pkg - shared types and constants of the window majority debouncer
// Sizes of the button set and history window, the per-button entry layout,
// the register map and the button-to-pin table.
// ----------------------------------------------------------------------------
package wmbd_pkg;

  localparam int NUM_BUTTONS   = 8;   // 1 .. 16
  localparam int HISTORY_DEPTH = 64;  // 2 .. 64

  localparam int BTN_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int POS_W   = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  // entry = {filtered level, high count, sample ring}
  localparam int ENTRY_W = 1 + CNT_W + HISTORY_DEPTH;

  localparam int LEVELS_W = 8;
  localparam int IDX_W    = 3;
  localparam int PIN_W    = 5;
  localparam int THR_W    = 7;

  localparam logic [THR_W-1:0] THR_RESET = 7'd53;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  // register index = paddr[CFG_ADDR_W-1:2]
  localparam logic REG_THRESHOLD = 1'b0;

  typedef logic [NUM_BUTTONS-1:0] btn_mask_t;

  function automatic logic [PIN_W-1:0] pin_of_button(input logic [IDX_W-1:0] idx);
    logic [PIN_W-1:0] pin;
    case (idx)
      3'd0:    pin = 5'd5;
      3'd1:    pin = 5'd7;
      3'd2:    pin = 5'd6;
      3'd3:    pin = 5'd8;
      3'd4:    pin = 5'd12;
      3'd5:    pin = 5'd14;
      3'd6:    pin = 5'd13;
      default: pin = 5'd15;
    endcase
    return pin;
  endfunction

  // index of the lowest set bit (zero when the mask is empty)
  function automatic logic [BTN_W-1:0] lowest_set(input btn_mask_t mask);
    logic [BTN_W-1:0] idx;
    idx = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (mask[i]) idx = BTN_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ sv/wmbd_ram.sv @@
// ----------------------------------------------------------------------------
// wmbd_ram - generic single-port-write, single-port-read RAM
// Registered read with read enable; a read and a write of the same address
// in one cycle return the old data.
// ----------------------------------------------------------------------------
module wmbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/window_majority_button_debouncer.sv @@
// ----------------------------------------------------------------------------
// window_majority_button_debouncer - sliding-window majority button filter
// Keeps a ring of recent samples and a running high count per button in a
// state RAM, updates one button per cycle unless the press queue stalls it, and
// emits a press beat for each button whose filtered level falls from high to low.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents                              accept
//  s_axis    in   tdata[7:0] pin_levels                      tvalid & tready
//  m_axis    out  tdata[2:0] button_index, [7:3] gpio_pin,   tvalid & tready
//                 tlast = last press of the poll
//  apb       in   0x0: high_count_threshold[6:0]             psel&penable&pwrite
//
// Flow: each poll makes one read-modify-write of the state RAM per button,
//   while the next poll can already wait in the input buffer; a poll's press
//   beats are loaded into the emit mask when its last button is written.
// Reset: per-entry valid bits clear the history at once; an entry never
//   written reads as all zeros. No clearing pass.
// Stalls: press beats drain from a mask register one per cycle while
//   m_axis_tready is high; if a poll finishes with presses while the previous
//   poll's beats are still queued, its final RAM write holds until the queue frees.
// ----------------------------------------------------------------------------
module window_majority_button_debouncer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // poll input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [wmbd_pkg::LEVELS_W-1:0]   s_axis_tdata,   // [7:0] pin_levels
  // press events
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // [2:0] button_index, [7:3] gpio_pin
  output logic                            m_axis_tlast,   // last_event
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wmbd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wmbd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wmbd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  import wmbd_pkg::*;

  localparam logic [BTN_W-1:0] LAST_BTN = BTN_W'(NUM_BUTTONS - 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(HISTORY_DEPTH - 1);

  // ---------------- configuration ----------------
  logic [THR_W-1:0] thr_q, thr_d;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1:2] == REG_THRESHOLD);

  always_comb begin
    thr_d = thr_q;
    if (cfg_wr) thr_d = pwdata[THR_W-1:0];
  end

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1:2] == REG_THRESHOLD) prdata = CFG_DATA_W'(thr_q);
  end

  // ---------------- input buffer and ring position ----------------
  logic                inbuf_valid_q, inbuf_valid_d;
  logic [LEVELS_W-1:0] inbuf_levels_q;
  logic [POS_W-1:0]    inbuf_pos_q;
  logic [POS_W-1:0]    wpos_q, wpos_d;
  logic                in_accept;

  assign s_axis_tready = !inbuf_valid_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // slot advances before each write, wrapping at the window depth
  assign wpos_d = !in_accept ? wpos_q : ((wpos_q == LAST_POS) ? '0 : wpos_q + 1'b1);

  // ---------------- read sequencer ----------------
  logic                busy_q, busy_d;
  logic [BTN_W-1:0]    btn_q, btn_d;
  logic [LEVELS_W-1:0] cur_levels_q;
  logic [POS_W-1:0]    cur_pos_q;
  logic                issue, issue_last, load_cur, stall_b, cur_level;

  assign issue      = busy_q && !stall_b;
  assign issue_last = issue && (btn_q == LAST_BTN);
  assign load_cur   = inbuf_valid_q && (!busy_q || issue_last);

  // buttons past the eighth always sample low
  assign cur_level  = (int'(btn_q) < LEVELS_W) ? cur_levels_q[btn_q[IDX_W-1:0]] : 1'b0;

  always_comb begin
    inbuf_valid_d = in_accept || (inbuf_valid_q && !load_cur);
    busy_d        = busy_q;
    btn_d         = btn_q;
    if (load_cur) begin
      busy_d = 1'b1;
      btn_d  = '0;
    end else if (issue) begin
      if (issue_last) busy_d = 1'b0;
      btn_d = btn_q + 1'b1;
    end
  end

  // ---------------- state RAM ----------------
  logic               ram_we;
  logic [BTN_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  wmbd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (btn_q),
    .rdata_o (ram_rdata)
  );

  // ---------------- update stage ----------------
  logic               b_valid_q, b_valid_d;
  logic [BTN_W-1:0]   b_btn_q;
  logic               b_level_q, b_last_q;
  logic [POS_W-1:0]   b_pos_q;
  btn_mask_t          entry_valid_q, entry_valid_d;
  // last cycle's write, forwarded when the same entry is read back-to-back
  logic               fwd_valid_q;
  logic [BTN_W-1:0]   fwd_addr_q;
  logic [ENTRY_W-1:0] fwd_data_q;
  btn_mask_t          acc_mask_q, acc_mask_d;

  logic [ENTRY_W-1:0]       entry;
  logic [HISTORY_DEPTH-1:0] hist, hist_new;
  logic [CNT_W-1:0]         cnt, cnt_new;
  logic                     filt, old_bit, up, fall, fire;
  btn_mask_t                fall_mask, poll_mask;

  // event queue
  btn_mask_t emit_mask_q, emit_mask_d;
  logic      emit_take, emit_free;

  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == b_btn_q)) begin
      entry = fwd_data_q;
    end else if (entry_valid_q[b_btn_q]) begin
      entry = ram_rdata;
    end else begin
      entry = '0;
    end
    hist = entry[HISTORY_DEPTH-1:0];
    cnt  = entry[HISTORY_DEPTH +: CNT_W];
    filt = entry[ENTRY_W-1];

    old_bit           = hist[b_pos_q];
    hist_new          = hist;
    hist_new[b_pos_q] = b_level_q;
    cnt_new           = cnt - CNT_W'(old_bit) + CNT_W'(b_level_q);
    up                = THR_W'(cnt_new) > thr_q;
    fall              = filt && !up;

    fall_mask          = '0;
    fall_mask[b_btn_q] = fall;
    poll_mask          = acc_mask_q | fall_mask;

    // final button of a poll with presses needs the queue free
    stall_b = b_valid_q && b_last_q && (poll_mask != '0) && !emit_free;
    fire    = b_valid_q && !stall_b;

    ram_we    = fire;
    ram_waddr = b_btn_q;
    ram_wdata = {up, cnt_new, hist_new};

    entry_valid_d = entry_valid_q;
    if (fire) entry_valid_d[b_btn_q] = 1'b1;

    acc_mask_d = acc_mask_q;
    if (fire) acc_mask_d = b_last_q ? '0 : poll_mask;

    b_valid_d = stall_b ? b_valid_q : issue;
  end

  // ---------------- event output ----------------
  logic onehot_left;

  assign m_axis_tvalid = (emit_mask_q != '0);
  assign emit_take     = m_axis_tvalid && m_axis_tready;
  assign onehot_left   = ((emit_mask_q & (emit_mask_q - 1'b1)) == '0);
  assign emit_free     = !m_axis_tvalid || (emit_take && onehot_left);

  always_comb begin
    logic [BTN_W-1:0] idx;
    idx          = lowest_set(emit_mask_q);
    m_axis_tdata = {pin_of_button(idx[IDX_W-1:0]), idx[IDX_W-1:0]};
    m_axis_tlast = onehot_left;

    emit_mask_d = emit_mask_q;
    if (emit_take) emit_mask_d = emit_mask_q & (emit_mask_q - 1'b1);
    if (fire && b_last_q && (poll_mask != '0)) emit_mask_d = poll_mask;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q         <= THR_RESET;
      inbuf_valid_q <= 1'b0;
      wpos_q        <= '0;
      busy_q        <= 1'b0;
      btn_q         <= '0;
      b_valid_q     <= 1'b0;
      fwd_valid_q   <= 1'b0;
      entry_valid_q <= '0;
      acc_mask_q    <= '0;
      emit_mask_q   <= '0;
    end else begin
      thr_q         <= thr_d;
      inbuf_valid_q <= inbuf_valid_d;
      wpos_q        <= wpos_d;
      busy_q        <= busy_d;
      btn_q         <= btn_d;
      b_valid_q     <= b_valid_d;
      fwd_valid_q   <= fire;
      entry_valid_q <= entry_valid_d;
      acc_mask_q    <= acc_mask_d;
      emit_mask_q   <= emit_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      inbuf_levels_q <= s_axis_tdata;
      inbuf_pos_q    <= wpos_d;
    end
    if (load_cur) begin
      cur_levels_q <= inbuf_levels_q;
      cur_pos_q    <= inbuf_pos_q;
    end
    if (issue) begin
      b_btn_q   <= btn_q;
      b_level_q <= cur_level;
      b_pos_q   <= cur_pos_q;
      b_last_q  <= (btn_q == LAST_BTN);
    end
    if (fire) begin
      fwd_addr_q <= ram_waddr;
      fwd_data_q <= ram_wdata;
    end
  end

endmodule

@@ sim/tb_window_majority_button_debouncer.sv @@
// ----------------------------------------------------------------------------
// tb_window_majority_button_debouncer - self-checking bench of the debouncer
// Drives polls of eight button levels through the stream input, writes and
// reads back the threshold register over APB, predicts every press beat from
// a local model of the sliding window and checks each output beat in order.
// ----------------------------------------------------------------------------
module tb_window_majority_button_debouncer;
  import wmbd_pkg::*;

  localparam int DRAIN_CYCLES = 3 * NUM_BUTTONS + 8;  // covers a poll with no presses
  localparam int LONG_HOLD    = 400;                  // receiver hold-off, cycles

  // pin of each button, lowest button in the lowest bits
  localparam logic [8*PIN_W-1:0] PIN_TABLE = {5'd15, 5'd13, 5'd14, 5'd12,
                                              5'd8, 5'd6, 5'd7, 5'd5};

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [PIN_W-1:0] pin;
    logic             last;
  } press_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [LEVELS_W-1:0]   s_axis_tdata  = '0;   // [7:0] pin_levels
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;         // [2:0] button_index, [7:3] gpio_pin
  logic                  m_axis_tlast;         // last_event
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  window_majority_button_debouncer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Window model: ring, running count and filtered level per button
  // --------------------------------------------------------------------------
  logic [HISTORY_DEPTH-1:0] win_ring  [NUM_BUTTONS];
  logic [CNT_W-1:0]         win_count [NUM_BUTTONS];
  logic                     win_level [NUM_BUTTONS];
  logic [POS_W-1:0]         win_pos;
  logic [THR_W-1:0]         win_thr;

  press_t press_q[$];   // press beats still owed by the block
  int     n_fail = 0;
  int     hold_token = 0;

  initial begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      win_ring[b]  = '0;
      win_count[b] = '0;
      win_level[b] = 1'b0;
    end
    win_pos = '0;
    win_thr = THR_RESET;
  end

  // one poll: slide every window, queue a press per falling filtered level
  task automatic slide_windows(input logic [LEVELS_W-1:0] lv);
    int unsigned pos;
    logic        old_bit;
    logic        new_bit;
    logic        up;
    int          first;
    press_t      ev;
    pos   = (int'(win_pos) + 1) % HISTORY_DEPTH;
    first = press_q.size();
    win_pos = POS_W'(pos);
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      new_bit = (b < 8) ? lv[b] : 1'b0;
      old_bit = win_ring[b][pos];
      win_ring[b][pos] = new_bit;
      win_count[b] = win_count[b] - CNT_W'(old_bit) + CNT_W'(new_bit);
      up = (win_count[b] > win_thr);
      if (up != win_level[b]) begin
        win_level[b] = up;
        if (!up) begin
          ev.idx  = IDX_W'(b);
          ev.pin  = PIN_TABLE[(b % 8) * PIN_W +: PIN_W];
          ev.last = 1'b0;
          press_q.push_back(ev);
        end
      end
    end
    if (press_q.size() > first) press_q[press_q.size() - 1].last = 1'b1;
  endtask

  // accepted poll beats and register writes feed the model
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) slide_windows(s_axis_tdata);
      if (psel && penable && pwrite && pready &&
          paddr[CFG_ADDR_W-1:2] == REG_THRESHOLD)
        win_thr <= pwdata[THR_W-1:0];
    end
  end

  // every press beat taken is matched against the oldest owed one
  always @(posedge clk_i) begin
    press_t exp_ev;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (press_q.size() == 0) begin
        $error("press beat with none owed: button_index %0d", m_axis_tdata[2:0]);
        n_fail++;
      end else begin
        exp_ev = press_q.pop_front();
        if (m_axis_tdata[2:0] !== exp_ev.idx) begin
          $error("button_index: expected %0d, got %0d", exp_ev.idx, m_axis_tdata[2:0]);
          n_fail++;
        end
        if (m_axis_tdata[7:3] !== exp_ev.pin) begin
          $error("gpio_pin: expected %0d, got %0d", exp_ev.pin, m_axis_tdata[7:3]);
          n_fail++;
        end
        if (m_axis_tlast !== exp_ev.last) begin
          $error("last_event: expected %0b, got %0b", exp_ev.last, m_axis_tlast);
          n_fail++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: a stall pattern that rotates through four ready modes, plus a long
  // hold-off whenever the test bumps hold_token
  // --------------------------------------------------------------------------
  int rx_cycle  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= rx_cycle[0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register access
  // --------------------------------------------------------------------------
  // offer one poll beat and hold it until taken; tvalid stays high afterwards
  task automatic send_poll(input logic [LEVELS_W-1:0] lv);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= lv;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic logic [LEVELS_W-1:0] biased_levels(input int unsigned p16);
    logic [LEVELS_W-1:0] v;
    for (int b = 0; b < LEVELS_W; b++) v[b] = ($urandom_range(0, 15) < p16);
    return v;
  endfunction

  // n polls, each button high with chance p16/16, sent in bursts with gaps
  task automatic run_polls(input int n, input int unsigned p16);
    int burst;
    int gap;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < n; i++) begin
      send_poll(biased_levels(p16));
      burst--;
      if (burst == 0) begin
        burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        gap   = $urandom_range(0, 6);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // stop sending, wait for every owed press, then let a silent poll finish
  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (press_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write the threshold (junk in the upper bits) and read it back
  task automatic set_threshold(input logic [THR_W-1:0] thr);
    logic [CFG_DATA_W-1:0] wd;
    wd = $urandom();
    wd[THR_W-1:0] = thr;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_THRESHOLD, 2'b00};
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[THR_W-1:0] !== thr) begin
      $error("high_count_threshold: expected %0d, got %0d", thr, prdata[THR_W-1:0]);
      n_fail++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // threshold written to its reset value, then level extremes and walking patterns
  task automatic test_directed_polls;
    set_threshold(THR_RESET);
    send_poll(8'h00);
    send_poll(8'hFF);
    for (int b = 0; b < 8; b++) send_poll(8'(1 << b));
    for (int b = 0; b < 8; b++) send_poll(~8'(1 << b));
    send_poll(8'hA5);
    send_poll(8'h5A);
    send_poll(8'hFF);
    send_poll(8'h00);
  endtask

  // count hovers around the threshold, lots of presses; the receiver holds
  // off long enough for the press queue to back up into the poll input
  task automatic test_mid_threshold;
    set_threshold(7'd32);
    run_polls(20, 8);
    hold_token++;
    run_polls(60, 8);
  endtask

  // reset threshold with mostly-high buttons; the sender drains once midway
  task automatic test_reset_threshold_biased;
    set_threshold(THR_RESET);
    run_polls(30, 14);
    wait_drained();
    run_polls(30, 14);
  endtask

  // threshold at and far above the depth: every high level falls on the
  // next poll and nothing rises again
  task automatic test_threshold_above_depth;
    set_threshold(7'(HISTORY_DEPTH));
    run_polls(10, 14);
    set_threshold(7'd127);
    run_polls(10, 16);
  endtask

  // one below a full window: only an all-high window counts as high
  task automatic test_top_threshold;
    set_threshold(7'(HISTORY_DEPTH - 1));
    run_polls(64, 16);
    run_polls(6, 12);
  endtask

  // zero threshold: a single high sample holds the level until it ages out
  task automatic test_zero_threshold;
    set_threshold(7'd0);
    run_polls(4, 8);
    run_polls(66, 0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_polls();
    test_mid_threshold();
    test_reset_threshold_biased();
    test_threshold_above_depth();
    test_top_threshold();
    test_zero_threshold();

    s_axis_tvalid <= 1'b0;
    for (int k = 0; k < 20000 && press_q.size() != 0; k++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (press_q.size() != 0) begin
      $error("press beats never delivered: %0d", press_q.size());
      n_fail++;
    end

    if (n_fail == 0) begin
      $display("** window_majority_button_debouncer: PASSED **");
    end else begin
      $display("** window_majority_button_debouncer: FAILED **");
    end
    $finish;
  end

  // watchdog, many times the slowest legal run
  initial begin
    #5000000;
    $display("** window_majority_button_debouncer: FAILED **");
    $finish;
  end

endmodule
